// ===== hdl/itoar_pkg.sv =====
// Package for the radix integer-to-ASCII converter: widths, sizing constants,
// the control/status structs between controller and datapath, and the digit-to-ASCII map.
// No dependencies.
`default_nettype none

package itoar_pkg;

  // Fixed field widths of the channels
  localparam int VALUE_BITS_W = 64;
  localparam int RADIX_W      = 6;
  localparam int CHAR_W       = 7;
  localparam int COUNT_W      = 7;

  // Datapath sizing
  localparam int VALUE_WIDTH   = 64;
  localparam int DIGIT_W       = 6;
  localparam int MAX_DIGITS    = VALUE_WIDTH;
  localparam int ADDR_W        = $clog2(MAX_DIGITS);
  localparam int NUM_W         = $clog2(MAX_DIGITS + 1);
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] DEC_DIGITS    = CHAR_W'(10);

  typedef struct packed {
    logic load;      // take a new item
    logic step;      // one division step
    logic rd;        // read digit memory
    logic out_load;  // fill output register
  } itoar_cmd_t;

  typedef struct packed {
    logic div_done;  // last digit produced this cycle
    logic last_idx;  // emitting the least significant digit
    logic out_free;  // output register can take a digit
  } itoar_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic lower);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (dw < DEC_DIGITS) begin
      return ASCII_ZERO + dw;
    end
    return dw - DEC_DIGITS + ASCII_UPPER_A + (lower ? CASE_OFFSET : '0);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itoar_in_if.sv =====
// Input channel interface: valid/ready plus one conversion request.
// Depends on itoar_pkg.
`default_nettype none

interface itoar_in_if;
  import itoar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [VALUE_BITS_W-1:0] value_bits;
  logic                    is_signed;
  logic [RADIX_W-1:0]      radix;
  logic                    lowercase;
  logic                    precision_zero;

  modport source (output valid, output value_bits, output is_signed, output radix,
                  output lowercase, output precision_zero, input ready);
  modport sink   (input valid, input value_bits, input is_signed, input radix,
                  input lowercase, input precision_zero, output ready);
endinterface

`default_nettype wire

// ===== hdl/itoar_out_if.sv =====
// Output channel interface: valid/ready plus one ASCII digit item.
// Depends on itoar_pkg.
`default_nettype none

interface itoar_out_if;
  import itoar_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  digit_char;
  logic [COUNT_W-1:0] digit_count;
  logic               is_last;

  modport source (output valid, output digit_char, output digit_count, output is_last,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input is_last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/itoar_ctrl.sv =====
// Controller FSM: sequences load, division steps and digit read-out.
// Depends on itoar_pkg.
`default_nettype none

module itoar_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire itoar_pkg::itoar_sts_t sts_i,
  output itoar_pkg::itoar_cmd_t      cmd_o
);
  import itoar_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.last_idx ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/itoar_dp.sv =====
// Datapath: magnitude/radix prep, digit-serial divider (8 quotient bits per cycle),
// digit memory and output register. Depends on itoar_pkg.
`default_nettype none

module itoar_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire itoar_pkg::itoar_cmd_t               cmd_i,
  output itoar_pkg::itoar_sts_t                    sts_o,
  input  wire logic [itoar_pkg::VALUE_BITS_W-1:0]  value_bits_i,
  input  wire logic                                is_signed_i,
  input  wire logic [itoar_pkg::RADIX_W-1:0]       radix_i,
  input  wire logic                                lowercase_i,
  input  wire logic                                precision_zero_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [itoar_pkg::CHAR_W-1:0]             digit_char_o,
  output logic [itoar_pkg::COUNT_W-1:0]            digit_count_o,
  output logic                                     is_last_o
);
  import itoar_pkg::*;

  logic [DIV_W-1:0]   v_q;
  logic [DIGIT_W-1:0] r_q;
  logic [RADIX_W-1:0] rad_q;
  logic               lower_q;
  logic               cnt_zero_q;
  logic [NUM_W-1:0]   n_q;
  logic [STEP_W-1:0]  step_q;
  logic [ADDR_W-1:0]  idx_q;
  logic [COUNT_W-1:0] count_q;
  logic [DIGIT_W-1:0] rd_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic [COUNT_W-1:0] ocount_q;
  logic               last_q;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  // Load-side prep
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RADIX_W-1:0]     rad_sat;

  always_comb begin
    val = value_bits_i[VALUE_WIDTH-1:0];
    mag = (is_signed_i && val[VALUE_WIDTH-1]) ? (~val + VALUE_WIDTH'(1)) : val;
    if (radix_i < RADIX_MIN) begin
      rad_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      rad_sat = RADIX_MAX;
    end else begin
      rad_sat = radix_i;
    end
  end

  // Restoring division over the top byte of v_q; remainder stays below the radix
  logic [BITS_PER_STEP-1:0] chunk;
  logic [BITS_PER_STEP-1:0] qbits;
  logic [DIGIT_W-1:0]       rem;
  logic [DIGIT_W:0]         trial;
  logic [DIV_W-1:0]         v_next;
  logic                     step_last;

  always_comb begin
    chunk = v_q[DIV_W-1 -: BITS_PER_STEP];
    rem   = r_q;
    qbits = '0;
    trial = '0;
    for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
      trial = {rem, chunk[i]};
      if (trial >= (DIGIT_W + 1)'(rad_q)) begin
        rem      = DIGIT_W'(trial - (DIGIT_W + 1)'(rad_q));
        qbits[i] = 1'b1;
      end else begin
        rem = trial[DIGIT_W-1:0];
      end
    end
    v_next    = (v_q << BITS_PER_STEP) | DIV_W'(qbits);
    step_last = (step_q == STEP_W'(DIV_STEPS - 1));
  end

  assign sts_o.div_done = step_last &&
                          ((v_next == '0) || (n_q == NUM_W'(MAX_DIGITS - 1)));
  assign sts_o.last_idx = (idx_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q        <= DIV_W'(mag);
      r_q        <= '0;
      rad_q      <= rad_sat;
      lower_q    <= lowercase_i;
      cnt_zero_q <= precision_zero_i && (mag == '0);
      n_q        <= '0;
      step_q     <= '0;
    end else if (cmd_i.step) begin
      v_q <= v_next;
      if (step_last) begin
        step_q <= '0;
        r_q    <= '0;
        n_q    <= n_q + NUM_W'(1);
        if (sts_o.div_done) begin
          idx_q   <= n_q[ADDR_W-1:0];
          count_q <= cnt_zero_q ? '0 : COUNT_W'(n_q + NUM_W'(1));
        end
      end else begin
        step_q <= step_q + STEP_W'(1);
        r_q    <= rem;
      end
    end else if (cmd_i.out_load) begin
      idx_q <= idx_q - ADDR_W'(1);
    end
  end

  // Digit store: written LSD first, read back MSD first
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && step_last) begin
      mem[n_q[ADDR_W-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      char_q   <= digit_to_ascii(rd_q, lower_q);
      ocount_q <= count_q;
      last_q   <= (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_count_o = ocount_q;
  assign is_last_o     = last_q;

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_radix.sv =====
// Top level of the radix integer-to-ASCII converter: controller plus datapath.
// Depends on itoar_pkg, itoar_in_if, itoar_out_if, itoar_ctrl, itoar_dp.
//
//   Channel | Dir | Carries
//   in_i    | in  | value_bits, is_signed, radix, lowercase, precision_zero
//   out_o   | out | digit_char, digit_count, is_last (one item per digit, MSD first)
//
// Each digit is produced by DIV_STEPS (8) steps of the shared divider, 8 quotient bits a cycle.
// Read-out of each digit is a memory read, then an output register load.
// Reset clears only the FSM state and the output valid flag.
// A stalled output holds the read-out; the next item is taken while the last digit waits.
`default_nettype none

module integer_to_ascii_radix (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itoar_in_if.sink    in_i,
  itoar_out_if.source out_o
);
  import itoar_pkg::*;

  itoar_cmd_t cmd;
  itoar_sts_t sts;

  itoar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itoar_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .value_bits_i     (in_i.value_bits),
    .is_signed_i      (in_i.is_signed),
    .radix_i          (in_i.radix),
    .lowercase_i      (in_i.lowercase),
    .precision_zero_i (in_i.precision_zero),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .digit_char_o     (out_o.digit_char),
    .digit_count_o    (out_o.digit_count),
    .is_last_o        (out_o.is_last)
  );

  // One command at a time from the sequencer
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.rd, cmd.out_load}))
    else $error("more than one datapath command");

  // Never overwrite an unaccepted digit
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // An accepted item blocks further input until its digits are done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while busy");

  // Emitted characters are digits or letters
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.digit_char >= 7'd48 && out_o.digit_char <= 7'd57) ||
                     (out_o.digit_char >= 7'd65 && out_o.digit_char <= 7'd90) ||
                     (out_o.digit_char >= 7'd97 && out_o.digit_char <= 7'd122)))
    else $error("digit character out of range");

endmodule

`default_nettype wire

// ===== test/itoar_digit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the radix integer-to-ASCII converter: watches both channels, predicts the
// digit items of every accepted request and compares them in order. Depends on itoar_pkg,
// itoar_in_if and itoar_out_if.

module itoar_digit_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  itoar_in_if   req_mon,
  itoar_out_if  dig_mon,
  output int    mismatches_o,
  output int    pending_o,
  output int    digits_o
);
  import itoar_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_exp_t;

  digit_exp_t expected_digits[$];
  int mismatch_cnt = 0;
  int digit_cnt    = 0;
  int pending_cnt  = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;
  assign digits_o     = digit_cnt;

  // Appends the digits of one request, most significant first.
  function automatic void predict_digits(input logic [VALUE_BITS_W-1:0] value_bits,
                                         input logic                    sgn,
                                         input logic [RADIX_W-1:0]      radix,
                                         input logic                    lower,
                                         input logic                    prec_zero);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] base;
    logic [DIGIT_W-1:0]     digs[$];
    logic [COUNT_W-1:0]     cnt;
    logic                   no_digits;
    digit_exp_t             e;
    mag = value_bits[VALUE_WIDTH-1:0];
    if (sgn && mag[VALUE_WIDTH-1]) begin
      mag = ~mag + 1'b1;  // most negative value stays exact as unsigned
    end
    if (radix < RADIX_MIN) begin
      base = VALUE_WIDTH'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = VALUE_WIDTH'(RADIX_MAX);
    end else begin
      base = VALUE_WIDTH'(radix);
    end
    no_digits = (mag == '0) && prec_zero;
    do begin
      digs.push_front(DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != '0);
    cnt = no_digits ? '0 : COUNT_W'(digs.size());
    for (int k = 0; k < digs.size(); k++) begin
      if (digs[k] < DIGIT_W'(10)) begin
        e.ch = ASCII_ZERO + CHAR_W'(digs[k]);
      end else begin
        e.ch = CHAR_W'(digs[k]) - DEC_DIGITS + ASCII_UPPER_A + (lower ? CASE_OFFSET : '0);
      end
      e.count = cnt;
      e.last  = (k == digs.size() - 1);
      expected_digits.push_back(e);
    end
  endfunction

  always @(posedge clk_i) begin
    digit_exp_t e;
    if (rst_ni) begin
      if (dig_mon.valid && dig_mon.ready) begin
        digit_cnt++;
        if (expected_digits.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected digit item: char %h count %0d last %b", $time,
                   dig_mon.digit_char, dig_mon.digit_count, dig_mon.is_last);
        end else begin
          e = expected_digits.pop_front();
          if (dig_mon.digit_char !== e.ch) begin
            mismatch_cnt++;
            $display("%0t: digit_char expected %h actual %h", $time, e.ch, dig_mon.digit_char);
          end
          if (dig_mon.digit_count !== e.count) begin
            mismatch_cnt++;
            $display("%0t: digit_count expected %0d actual %0d", $time, e.count,
                     dig_mon.digit_count);
          end
          if (dig_mon.is_last !== e.last) begin
            mismatch_cnt++;
            $display("%0t: is_last expected %b actual %b", $time, e.last, dig_mon.is_last);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_digits(req_mon.value_bits, req_mon.is_signed, req_mon.radix,
                       req_mon.lowercase, req_mon.precision_zero);
      end
    end
    pending_cnt = expected_digits.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, request stimulus and output back-pressure.
// Depends on itoar_pkg, both channel interfaces, integer_to_ascii_radix and itoar_digit_checker.

module testbench;
  import itoar_pkg::*;

  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int STALL_LIMIT  = 6000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 78;

  logic clk_i;
  logic rst_ni;
  logic hold_req;
  logic rx_hold;
  int   idle_pct;
  int   stall_pct;
  int   sent;
  int   quiet_cycles;
  int   mismatches;
  int   pending;
  int   digits;

  itoar_in_if  in_ch();
  itoar_out_if out_ch();

  integer_to_ascii_radix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  itoar_digit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (in_ch),
    .dig_mon      (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .digits_o     (digits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: random stalls, forced low while a hold-off runs.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= rst_ni && !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    rx_hold <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d digits outstanding", $time,
               quiet_cycles, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request; valid stays high into the next call when there is no gap.
  task automatic send_req(input logic [VALUE_BITS_W-1:0] value, input logic sgn,
                          input logic [RADIX_W-1:0] radix, input logic lower,
                          input logic prec_zero);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.value_bits     <= value;
    in_ch.is_signed      <= sgn;
    in_ch.radix          <= radix;
    in_ch.lowercase      <= lower;
    in_ch.precision_zero <= prec_zero;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Mostly short values so radix-2 requests stay cheap; a few off-range radices.
  task automatic send_random_req();
    logic [VALUE_BITS_W-1:0] value;
    logic [RADIX_W-1:0]      radix;
    int                      sel;
    value = {$urandom, $urandom} >> $urandom_range(0, 63);
    if ($urandom_range(0, 3) == 0) value = ~value;
    if ($urandom_range(0, 15) == 0) value = '0;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      radix = RADIX_W'($urandom_range(0, 63));
    end else if (sel < 5) begin
      case ($urandom_range(0, 3))
        0:       radix = RADIX_W'(2);
        1:       radix = RADIX_W'(8);
        2:       radix = RADIX_W'(10);
        default: radix = RADIX_W'(16);
      endcase
    end else begin
      radix = RADIX_W'($urandom_range(2, 36));
    end
    send_req(value, 1'($urandom_range(0, 1)), radix, 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
  endtask

  // Stops offering and waits until every predicted digit has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni               = 1'b0;
    hold_req             <= 1'b0;
    idle_pct             <= 0;
    stall_pct            <= 0;
    sent                 = 0;
    quiet_cycles         <= 0;
    in_ch.valid          <= 1'b0;
    in_ch.value_bits     <= '0;
    in_ch.is_signed      <= 1'b0;
    in_ch.radix          <= RADIX_MIN;
    in_ch.lowercase      <= 1'b0;
    in_ch.precision_zero <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero with and without precision, extremes, letters, radix saturation.
    send_req(64'd0, 1'b0, 6'd10, 1'b0, 1'b0);
    send_req(64'd0, 1'b0, 6'd10, 1'b0, 1'b1);
    send_req(64'd0, 1'b1, 6'd16, 1'b1, 1'b1);
    send_req('1, 1'b0, 6'd2, 1'b0, 1'b0);
    send_req('1, 1'b1, 6'd10, 1'b0, 1'b1);
    send_req(64'h8000_0000_0000_0000, 1'b1, 6'd2, 1'b0, 1'b0);
    send_req(64'h8000_0000_0000_0000, 1'b1, 6'd10, 1'b0, 1'b1);
    send_req(64'h8000_0000_0000_0000, 1'b0, 6'd36, 1'b1, 1'b0);
    send_req('1, 1'b0, 6'd36, 1'b0, 1'b0);
    send_req('1, 1'b0, 6'd36, 1'b1, 1'b1);
    send_req(64'd35, 1'b0, 6'd36, 1'b0, 1'b0);
    send_req(64'd35, 1'b0, 6'd36, 1'b1, 1'b0);
    send_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd16, 1'b1, 1'b0);
    send_req(64'd255, 1'b0, 6'd16, 1'b0, 1'b0);
    send_req(64'd5, 1'b0, 6'd0, 1'b0, 1'b0);
    send_req(64'd5, 1'b1, 6'd1, 1'b0, 1'b1);
    send_req(64'd1295, 1'b0, 6'd37, 1'b1, 1'b0);
    send_req('1, 1'b0, 6'd63, 1'b0, 1'b0);
    send_req(64'd8, 1'b0, 6'd8, 1'b0, 1'b0);
    send_req(64'd1, 1'b0, 6'd2, 1'b0, 1'b1);
    send_req(64'd10, 1'b0, 6'd11, 1'b0, 1'b0);
    send_req(-64'sd36, 1'b1, 6'd36, 1'b1, 1'b0);
    send_req(64'd12345678, 1'b0, 6'd3, 1'b1, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 51; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 51; end
        default: begin idle_pct <= 9; stall_pct <= 9; end
      endcase
      @(posedge clk_i);
      if (ph == 0) begin
        // Output held off while requests keep coming: the input must back up.
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      repeat (PHASE_ITEMS) send_random_req();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (directed extremes, saturated radices, four idle/stall mixes,",
             sent);
    $display("one long output hold-off) and checked %0d digit items.", digits);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
